@@ design/ldcq_pkg.sv @@
// ----------------------------------------------------------------------------
// LED driver command queue decoder package
// Shared codes, stage records and the reverse seven-segment lookup.
// ----------------------------------------------------------------------------
package ldcq_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_DATA  = 2'd2,
    OP_RUN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RS_WAIT_CMD  = 2'd0,
    RS_WAIT_DATA = 2'd1,
    RS_FULL      = 2'd2
  } rx_state_e;

  typedef enum logic [2:0] {
    ET_NONE = 3'd0,
    ET_ADDR = 3'd1,
    ET_SYS  = 3'd2,
    ET_DISP = 3'd3,
    ET_DIM  = 3'd4,
    ET_DATA = 3'd5
  } entry_type_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_DIGIT = 3'd1,
    ACT_POWER = 3'd2,
    ACT_BLINK = 3'd3,
    ACT_DUTY  = 3'd4
  } action_e;

  localparam logic [3:0] NibAddr = 4'h0;
  localparam logic [3:0] NibSys  = 4'h2;
  localparam logic [3:0] NibDisp = 4'h8;
  localparam logic [3:0] NibDim  = 4'he;

  localparam logic [7:0] CodeUnknown = 8'h7f;

  localparam logic [3:0] PtrDigit1 = 4'd0;
  localparam logic [3:0] PtrDigit2 = 4'd2;
  localparam logic [3:0] PtrDigit3 = 4'd6;
  localparam logic [3:0] PtrDigit4 = 4'd8;

  localparam logic [6:0] SegTable [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  // queue stage record: classifier results plus the popped entry
  typedef struct packed {
    logic        ack;
    logic [5:0]  count;
    logic        pop;
    entry_type_e etype;
    logic [7:0]  data;
  } stg_t;

  typedef struct packed {
    logic        ack;
    logic [5:0]  count;
    action_e     action;
    logic [2:0]  digit_position;
    logic [7:0]  digit_code;
    logic        power_on;
    logic [1:0]  blink_mode;
    logic [3:0]  duty;
  } res_t;

  function automatic logic [7:0] seg_decode(input logic [7:0] b);
    logic [7:0] code;
    logic       found;
    code  = CodeUnknown;
    found = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!found && b[6:0] == SegTable[i]) begin
        code  = {b[7], 3'b000, 4'(i)};
        found = 1'b1;
      end
    end
    return code;
  endfunction

endpackage

@@ design/led_driver_command_queue_decoder.sv @@
// ----------------------------------------------------------------------------
// LED driver command queue decoder
// A result passes the queue stage register, then the result register.
// Throughput: one transaction per cycle unless stalled; queue storage is
// one write port and one registered read port. Reset clears receive state,
// queue pointers, count and display pointer; queue storage is not cleared.
// ----------------------------------------------------------------------------
module led_driver_command_queue_decoder #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] bus_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ack_o,
  output logic [5:0] queue_count_o,
  output logic [2:0] action_o,
  output logic [2:0] digit_position_o,
  output logic [7:0] digit_code_o,
  output logic       power_on_o,
  output logic [1:0] blink_mode_o,
  output logic [3:0] duty_o
);
  import ldcq_pkg::*;

  logic s1_valid_q, out_valid_q;
  logic in_accept, out_load;
  stg_t stg;
  res_t res;

  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept || (s1_valid_q && !out_load);
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  ldcq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .accept_i   (in_accept),
    .opcode_i,
    .bus_byte_i,
    .stg_o      (stg)
  );

  ldcq_exec u_exec (
    .clk_i,
    .rst_ni,
    .load_i (out_load),
    .stg_i  (stg),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign ack_o            = res.ack;
  assign queue_count_o    = res.count;
  assign action_o         = res.action;
  assign digit_position_o = res.digit_position;
  assign digit_code_o     = res.digit_code;
  assign power_on_o       = res.power_on;
  assign blink_mode_o     = res.blink_mode;
  assign duty_o           = res.duty;

endmodule

@@ design/ldcq_queue.sv @@
// ----------------------------------------------------------------------------
// LED driver command queue
// Receive classifier, ring-buffer command queue and stage register.
// ----------------------------------------------------------------------------
module ldcq_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          bus_byte_i,
  output ldcq_pkg::stg_t      stg_o
);
  import ldcq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  rx_state_e       rs_q, rs_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] used_q, used_d;
  logic            push, pop, ack;
  entry_type_e     ptype;
  entry_type_e     cls;
  logic            full;

  logic [10:0]     mem [QUEUE_DEPTH];
  logic [10:0]     rdata_q;
  logic            ack_q, pop_q;
  logic [5:0]      count_q;

  assign full = (used_q == CntFull);

  always_comb begin
    case (bus_byte_i[7:4])
      NibAddr: cls = ET_ADDR;
      NibSys:  cls = ET_SYS;
      NibDisp: cls = ET_DISP;
      NibDim:  cls = ET_DIM;
      default: cls = ET_NONE;
    endcase
  end

  always_comb begin
    rs_d  = rs_q;
    push  = 1'b0;
    pop   = 1'b0;
    ack   = 1'b0;
    ptype = cls;
    if (accept_i) begin
      case (opcode_e'(opcode_i))
        OP_START, OP_STOP: rs_d = RS_WAIT_CMD;
        OP_DATA: begin
          case (rs_q)
            RS_WAIT_CMD: begin
              if (cls != ET_NONE) begin
                if (!full) begin
                  push = 1'b1;
                  ack  = 1'b1;
                  if (cls == ET_ADDR) rs_d = RS_WAIT_DATA;
                end else begin
                  rs_d = RS_FULL;
                end
              end
            end
            RS_WAIT_DATA: begin
              ack   = 1'b1;
              ptype = ET_DATA;
              if (!full) push = 1'b1;
              else       rs_d = RS_FULL;
            end
            default: ;
          endcase
        end
        OP_RUN: pop = (used_q != '0);
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    used_d = used_q;
    if (push) begin
      tail_d = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
      used_d = used_q + 1'b1;
    end
    if (pop) begin
      head_d = (head_q == IdxLast) ? '0 : head_q + 1'b1;
      used_d = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= RS_WAIT_CMD;
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
      pop_q  <= 1'b0;
    end else begin
      rs_q   <= rs_d;
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
      if (accept_i) pop_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ack_q   <= ack;
      count_q <= 6'(used_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem[tail_q] <= {ptype, bus_byte_i};
    if (pop)  rdata_q     <= mem[head_q];
  end

  assign stg_o.ack   = ack_q;
  assign stg_o.count = count_q;
  assign stg_o.pop   = pop_q;
  assign stg_o.etype = entry_type_e'(rdata_q[10:8]);
  assign stg_o.data  = rdata_q[7:0];

endmodule

@@ design/ldcq_exec.sv @@
// ----------------------------------------------------------------------------
// LED driver command executor
// Runs a popped entry, tracks the display pointer, holds the result register.
// ----------------------------------------------------------------------------
module ldcq_exec (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ldcq_pkg::stg_t stg_i,
  output ldcq_pkg::res_t res_o
);
  import ldcq_pkg::*;

  logic [3:0] ptr_q, ptr_d;
  res_t       res_q, res_d;

  always_comb begin
    ptr_d                = ptr_q;
    res_d                = '0;
    res_d.ack            = stg_i.ack;
    res_d.count          = stg_i.count;
    res_d.action         = ACT_NONE;
    if (stg_i.pop) begin
      case (stg_i.etype)
        ET_ADDR: ptr_d = stg_i.data[3:0];
        ET_DATA: begin
          case (ptr_q)
            PtrDigit1: res_d.digit_position = 3'd1;
            PtrDigit2: res_d.digit_position = 3'd2;
            PtrDigit3: res_d.digit_position = 3'd3;
            PtrDigit4: res_d.digit_position = 3'd4;
            default:   res_d.digit_position = 3'd0;
          endcase
          if (res_d.digit_position != 3'd0) begin
            res_d.action     = ACT_DIGIT;
            res_d.digit_code = seg_decode(stg_i.data);
          end
          ptr_d = ptr_q + 4'd1;
        end
        ET_SYS: begin
          res_d.action   = ACT_POWER;
          res_d.power_on = stg_i.data[0];
        end
        ET_DISP: begin
          res_d.action     = ACT_BLINK;
          res_d.blink_mode = stg_i.data[2:1];
        end
        ET_DIM: begin
          res_d.action = ACT_DUTY;
          res_d.duty   = stg_i.data[3:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (load_i) begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED driver command queue decoder testbench
// Drives bus events (start, stop, bytes, run) under random handshake gaps
// and checks each result transaction against a cycle-free behavioral
// predictor of the classifier, command queue and executor, or a fixed result.
// ----------------------------------------------------------------------------
module testbench;
  import ldcq_pkg::*;

  localparam int unsigned QDEPTH    = 32;
  localparam int unsigned ITEM_GOAL = 700;

  typedef struct packed {
    entry_type_e kind;
    logic [7:0]  value;
  } cmd_entry_t;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] data;
    logic       typed;
    res_t       result;
  } step_t;

  localparam res_t RES_NONE       = '0;
  localparam res_t RES_QUEUED_ONE = '{1'b1, 6'd1, ACT_NONE, 3'd0, 8'h00, 1'b0, 2'd0, 4'd0};

  localparam logic [6:0] HEX_GLYPHS [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  localparam step_t DIRECTED [22] = '{
    '{OP_RUN,   8'h00, 1'b1, RES_NONE},
    '{OP_DATA,  8'h55, 1'b1, RES_NONE},
    '{OP_DATA,  8'hFF, 1'b1, RES_NONE},
    '{OP_START, 8'h00, 1'b1, RES_NONE},
    '{OP_DATA,  8'h21, 1'b1, RES_QUEUED_ONE},
    '{OP_DATA,  8'h87, 1'b0, RES_NONE},
    '{OP_DATA,  8'hEF, 1'b0, RES_NONE},
    '{OP_DATA,  8'h20, 1'b0, RES_NONE},
    '{OP_DATA,  8'h00, 1'b0, RES_NONE},
    '{OP_DATA,  8'hFF, 1'b0, RES_NONE},
    '{OP_DATA,  8'h00, 1'b0, RES_NONE},
    '{OP_DATA,  8'hF1, 1'b0, RES_NONE},
    '{OP_STOP,  8'hFF, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'hFF, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'h00, 1'b0, RES_NONE},
    '{OP_RUN,   8'hA5, 1'b1, RES_NONE}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] opcode_i;
  logic [7:0] bus_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       ack_o;
  logic [5:0] queue_count_o;
  logic [2:0] action_o;
  logic [2:0] digit_position_o;
  logic [7:0] digit_code_o;
  logic       power_on_o;
  logic [1:0] blink_mode_o;
  logic [3:0] duty_o;

  led_driver_command_queue_decoder #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .bus_byte_i      (bus_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ack_o           (ack_o),
    .queue_count_o   (queue_count_o),
    .action_o        (action_o),
    .digit_position_o(digit_position_o),
    .digit_code_o    (digit_code_o),
    .power_on_o      (power_on_o),
    .blink_mode_o    (blink_mode_o),
    .duty_o          (duty_o)
  );

  // predictor state
  rx_state_e   rx_state;
  cmd_entry_t  cmd_ring [QDEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_used;
  logic [3:0]  disp_ptr;

  res_t        expected_results [$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          quiet_in;
  bit          quiet_out;

  function automatic logic [7:0] segment_to_hex(input logic [7:0] b);
    for (int i = 0; i < 16; i++) begin
      if (b[6:0] == HEX_GLYPHS[i]) return {b[7], 3'b000, 4'(i)};
    end
    return CodeUnknown;
  endfunction

  function automatic bit ring_push(input entry_type_e kind, input logic [7:0] b);
    if (ring_used >= QDEPTH) return 1'b0;
    cmd_ring[ring_tail] = '{kind, b};
    ring_tail = (ring_tail + 1) % QDEPTH;
    ring_used++;
    return 1'b1;
  endfunction

  function automatic res_t predict_transaction(input opcode_e op, input logic [7:0] b);
    res_t        r;
    entry_type_e kind;
    cmd_entry_t  e;
    r = '0;
    case (op)
      OP_START, OP_STOP: rx_state = RS_WAIT_CMD;
      OP_DATA: begin
        if (rx_state == RS_WAIT_CMD) begin
          case (b[7:4])
            NibAddr: kind = ET_ADDR;
            NibSys:  kind = ET_SYS;
            NibDisp: kind = ET_DISP;
            NibDim:  kind = ET_DIM;
            default: kind = ET_NONE;
          endcase
          if (kind != ET_NONE) begin
            if (ring_push(kind, b)) begin
              r.ack = 1'b1;
              if (kind == ET_ADDR) rx_state = RS_WAIT_DATA;
            end else begin
              rx_state = RS_FULL;
            end
          end
        end else if (rx_state == RS_WAIT_DATA) begin
          r.ack = 1'b1;
          if (!ring_push(ET_DATA, b)) rx_state = RS_FULL;
        end
      end
      OP_RUN: begin
        if (ring_used > 0) begin
          e = cmd_ring[ring_head];
          ring_head = (ring_head + 1) % QDEPTH;
          ring_used--;
          case (e.kind)
            ET_ADDR: disp_ptr = e.value[3:0];
            ET_DATA: begin
              case (disp_ptr)
                PtrDigit1: r.digit_position = 3'd1;
                PtrDigit2: r.digit_position = 3'd2;
                PtrDigit3: r.digit_position = 3'd3;
                PtrDigit4: r.digit_position = 3'd4;
                default:   r.digit_position = 3'd0;
              endcase
              if (r.digit_position != 3'd0) begin
                r.action     = ACT_DIGIT;
                r.digit_code = segment_to_hex(e.value);
              end
              disp_ptr = disp_ptr + 4'd1;
            end
            ET_SYS: begin
              r.action   = ACT_POWER;
              r.power_on = e.value[0];
            end
            ET_DISP: begin
              r.action     = ACT_BLINK;
              r.blink_mode = e.value[2:1];
            end
            ET_DIM: begin
              r.action = ACT_DUTY;
              r.duty   = e.value[3:0];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    r.count = ring_used[5:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] display_byte();
    if ($urandom_range(0, 2) != 0)
      return {1'($urandom_range(0, 1)), HEX_GLYPHS[$urandom_range(0, 15)]};
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] command_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return {NibSys, 4'($urandom)};
      3, 4, 5: return {NibDisp, 4'($urandom)};
      6, 7, 8: return {NibDim, 4'($urandom)};
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // called at a rising edge; returns at a rising edge
  task automatic send(input opcode_e op, input logic [7:0] b, input logic typed,
                      input res_t typed_res);
    res_t        r;
    int unsigned gap;
    opcode_i   <= op;
    bus_byte_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_transaction(op, b);
    expected_results.push_back(typed ? typed_res : r);
    items_sent++;
    gap = pick_gap(quiet_in);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    quiet_out   = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned hold;
      if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
      hold = pick_gap(quiet_out);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, action", action_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (ack_o !== want.ack) report_mismatch("ack", ack_o, want.ack);
        if (queue_count_o !== want.count)
          report_mismatch("queue_count", queue_count_o, want.count);
        if (action_o !== want.action) report_mismatch("action", action_o, want.action);
        if (digit_position_o !== want.digit_position)
          report_mismatch("digit_position", digit_position_o, want.digit_position);
        if (digit_code_o !== want.digit_code)
          report_mismatch("digit_code", digit_code_o, want.digit_code);
        if (power_on_o !== want.power_on)
          report_mismatch("power_on", power_on_o, want.power_on);
        if (blink_mode_o !== want.blink_mode)
          report_mismatch("blink_mode", blink_mode_o, want.blink_mode);
        if (duty_o !== want.duty) report_mismatch("duty", duty_o, want.duty);
      end
    end
  end

  initial begin
    int unsigned roll;
    int unsigned n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_START;
    bus_byte_i = 8'h00;
    quiet_in   = 1'b0;
    mismatches = 0;
    items_sent = 0;
    rx_state   = RS_WAIT_CMD;
    ring_head  = 0;
    ring_tail  = 0;
    ring_used  = 0;
    disp_ptr   = 4'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      send(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].result);

    while (items_sent < ITEM_GOAL) begin
      quiet_in = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send(OP_START, 8'($urandom), 1'b0, RES_NONE);
        send(OP_DATA, {NibAddr, 4'($urandom)}, 1'b0, RES_NONE);
        repeat ($urandom_range(1, 10)) send(OP_DATA, display_byte(), 1'b0, RES_NONE);
        send(OP_STOP, 8'($urandom), 1'b0, RES_NONE);
      end else if (roll < 52) begin
        send(OP_START, 8'($urandom), 1'b0, RES_NONE);
        repeat ($urandom_range(1, 4)) send(OP_DATA, command_byte(), 1'b0, RES_NONE);
        send(OP_STOP, 8'($urandom), 1'b0, RES_NONE);
      end else if (roll < 85) begin
        repeat ($urandom_range(1, ring_used + 2)) send(OP_RUN, 8'($urandom), 1'b0, RES_NONE);
      end else if (roll < 93) begin
        // overfill the queue, then sometimes poke it while it is full
        send(OP_START, 8'($urandom), 1'b0, RES_NONE);
        send(OP_DATA, {NibAddr, 4'($urandom)}, 1'b0, RES_NONE);
        n = QDEPTH - ring_used + $urandom_range(1, 4);
        repeat (n) send(OP_DATA, display_byte(), 1'b0, RES_NONE);
        if ($urandom_range(0, 1) == 1) begin
          send(OP_START, 8'($urandom), 1'b0, RES_NONE);
          repeat ($urandom_range(1, 3)) send(OP_DATA, command_byte(), 1'b0, RES_NONE);
          send(OP_DATA, display_byte(), 1'b0, RES_NONE);
        end
        send(OP_STOP, 8'($urandom), 1'b0, RES_NONE);
      end else begin
        repeat ($urandom_range(1, 4))
          send(opcode_e'($urandom_range(0, 3)), 8'($urandom), 1'b0, RES_NONE);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ldcq_pkg.sv
design/ldcq_queue.sv
design/ldcq_exec.sv
design/led_driver_command_queue_decoder.sv
test/testbench.sv
